@@ hdl/assert_macros.svh @@
// Assertion macros for the RTL modules of the depacketizer; the output stage uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hdl/h264rtp_pkg.sv @@
// Package with types and constants for the H.264 RTP depacketizer.
package h264rtp_pkg;

    // Width of the packet length and byte offset.
    localparam int LENGTH_BITS = 16;
    // Width of the STAP-A end-of-entry sum.
    localparam int SUM_BITS = 17;

    // NAL unit types found in the first payload byte.
    localparam logic [4:0] NAL_SINGLE_MIN = 5'd1;
    localparam logic [4:0] NAL_SINGLE_MAX = 5'd23;
    localparam logic [4:0] NAL_STAP_A     = 5'd24;
    localparam logic [4:0] NAL_FU_A       = 5'd28;

    // Number of bytes in an Annex-B start code.
    localparam logic [2:0] START_CODE_LEN = 3'd4;

    typedef enum logic [1:0] {
        KIND_DROP   = 2'd0,
        KIND_SINGLE = 2'd1,
        KIND_STAP   = 2'd2,
        KIND_FU     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PHASE_SIZE_HIGH = 2'd0,
        PHASE_SIZE_LOW  = 2'd1,
        PHASE_DATA      = 2'd2
    } phase_t;

    // Results planned for one input transfer, handed to the output stage.
    typedef struct packed {
        logic       load;
        logic       start_code;
        logic       byte_en;
        logic [7:0] data;
        logic       au_end;
    } plan_t;

endpackage

@@ hdl/h264rtp_parse.sv @@
// Payload parser: packet state and the result plan for each input byte.
module h264rtp_parse (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   in_ready,
    input  logic [7:0]             s_data_byte,
    input  logic                   s_first_of_packet,
    input  logic [15:0]            s_packet_length,
    input  logic                   s_rtp_marker,
    output h264rtp_pkg::plan_t     plan
);
    import h264rtp_pkg::*;

    logic [LENGTH_BITS-1:0] offset_reg, offset_next, offset_eff;
    logic [LENGTH_BITS-1:0] length_reg, length_next;
    logic                   marker_reg, marker_next;
    kind_t                  kind_reg, kind_next;
    logic [2:0]             ind_reg, ind_next;
    phase_t                 phase_reg, phase_next;
    logic [7:0]             size_high_reg, size_high_next;
    logic [15:0]            entry_reg, entry_next;
    logic                   frag_active_reg, frag_active_next;
    logic                   frag_pass_reg, frag_pass_next;
    logic                   frag_end_reg, frag_end_next;
    logic                   has_data_reg, has_data_next;

    logic                   accept;
    logic [4:0]             hdr_type;
    logic [15:0]            entry_size;
    logic [SUM_BITS-1:0]    entry_end;
    logic                   emit_sc;
    logic                   emit_byte;
    logic [7:0]             emit_data;
    logic                   emit_au;
    logic                   data_seen;

    assign accept     = s_valid && in_ready;
    assign hdr_type   = s_data_byte[4:0];
    assign entry_size = {size_high_reg, s_data_byte};

    // Decode one byte against the packet state.
    always_comb begin
        // A first byte restarts the packet and closes a fragment run whose end was pending.
        kind_next        = s_first_of_packet ? KIND_DROP : kind_reg;
        frag_active_next = (s_first_of_packet && frag_end_reg) ? 1'b0 : frag_active_reg;
        frag_end_next    = s_first_of_packet ? 1'b0 : frag_end_reg;
        frag_pass_next   = s_first_of_packet ? 1'b0 : frag_pass_reg;
        length_next      = s_first_of_packet ? s_packet_length[LENGTH_BITS-1:0] : length_reg;
        marker_next      = s_first_of_packet ? s_rtp_marker : marker_reg;
        offset_eff       = s_first_of_packet ? '0 : offset_reg;
        phase_next       = s_first_of_packet ? PHASE_SIZE_HIGH : phase_reg;
        entry_next       = s_first_of_packet ? 16'd0 : entry_reg;
        ind_next         = ind_reg;
        size_high_next   = size_high_reg;
        has_data_next    = has_data_reg;
        offset_next      = offset_eff;
        entry_end        = SUM_BITS'(offset_eff) + SUM_BITS'(1) + SUM_BITS'(entry_size);
        emit_sc          = 1'b0;
        emit_byte        = 1'b0;
        emit_data        = s_data_byte;
        emit_au          = 1'b0;
        data_seen        = 1'b0;

        if (offset_eff < length_next) begin
            if (offset_eff == '0) begin
                // Packet header byte selects how the payload is handled.
                if (hdr_type >= NAL_SINGLE_MIN && hdr_type <= NAL_SINGLE_MAX) begin
                    kind_next        = KIND_SINGLE;
                    frag_active_next = 1'b0;
                    emit_sc          = 1'b1;
                    emit_byte        = 1'b1;
                end else if (hdr_type == NAL_STAP_A) begin
                    kind_next        = KIND_STAP;
                    frag_active_next = 1'b0;
                end else if (hdr_type == NAL_FU_A) begin
                    kind_next = KIND_FU;
                    ind_next  = s_data_byte[7:5];
                end else begin
                    kind_next = KIND_DROP;
                end
            end else begin
                case (kind_next)
                    KIND_SINGLE: begin
                        emit_byte = 1'b1;
                    end
                    KIND_STAP: begin
                        case (phase_next)
                            PHASE_SIZE_HIGH: begin
                                size_high_next = s_data_byte;
                                phase_next     = PHASE_SIZE_LOW;
                            end
                            PHASE_SIZE_LOW: begin
                                // An entry running past the packet drops the rest.
                                if (entry_end > SUM_BITS'(length_next)) begin
                                    kind_next = KIND_DROP;
                                end else begin
                                    emit_sc    = 1'b1;
                                    entry_next = entry_size;
                                    phase_next = (entry_size != 16'd0) ? PHASE_DATA
                                                                       : PHASE_SIZE_HIGH;
                                end
                            end
                            default: begin
                                emit_byte  = 1'b1;
                                entry_next = entry_next - 16'd1;
                                if (entry_next == 16'd0) begin
                                    phase_next = PHASE_SIZE_HIGH;
                                end
                            end
                        endcase
                    end
                    KIND_FU: begin
                        if (offset_eff == LENGTH_BITS'(1)) begin
                            // Fragment header: start bit rebuilds the NAL header.
                            frag_end_next = s_data_byte[6];
                            if (s_data_byte[7]) begin
                                emit_sc          = 1'b1;
                                emit_byte        = 1'b1;
                                emit_data        = {ind_next, s_data_byte[4:0]};
                                frag_active_next = 1'b1;
                                frag_pass_next   = 1'b1;
                            end else begin
                                frag_pass_next = frag_active_next;
                            end
                        end else if (frag_pass_next) begin
                            emit_byte = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            offset_next = offset_eff + LENGTH_BITS'(1);
            data_seen   = has_data_reg || emit_sc || emit_byte;
            has_data_next = data_seen;

            // Packet end: close the fragment run if its end bit was seen, and flush on the marker once data was seen.
            if (offset_next == length_next) begin
                if (frag_end_next) begin
                    frag_active_next = 1'b0;
                end
                frag_end_next  = 1'b0;
                frag_pass_next = 1'b0;
                if (marker_next && data_seen &&
                    !(kind_next == KIND_FU && length_next < LENGTH_BITS'(2))) begin
                    emit_au          = 1'b1;
                    has_data_next    = 1'b0;
                    frag_active_next = 1'b0;
                end
            end
        end

        plan.load       = accept && (emit_sc || emit_byte || emit_au);
        plan.start_code = emit_sc;
        plan.byte_en    = emit_byte;
        plan.data       = emit_data;
        plan.au_end     = emit_au;
    end

    // Packet state registers, updated on each input transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg      <= '0;
            length_reg      <= '0;
            marker_reg      <= 1'b0;
            kind_reg        <= KIND_DROP;
            ind_reg         <= 3'd0;
            phase_reg       <= PHASE_SIZE_HIGH;
            size_high_reg   <= 8'd0;
            entry_reg       <= 16'd0;
            frag_active_reg <= 1'b0;
            frag_pass_reg   <= 1'b0;
            frag_end_reg    <= 1'b0;
            has_data_reg    <= 1'b0;
        end else if (accept) begin
            offset_reg      <= offset_next;
            length_reg      <= length_next;
            marker_reg      <= marker_next;
            kind_reg        <= kind_next;
            ind_reg         <= ind_next;
            phase_reg       <= phase_next;
            size_high_reg   <= size_high_next;
            entry_reg       <= entry_next;
            frag_active_reg <= frag_active_next;
            frag_pass_reg   <= frag_pass_next;
            frag_end_reg    <= frag_end_next;
            has_data_reg    <= has_data_next;
        end
    end

endmodule

@@ hdl/h264rtp_emit.sv @@
// Output stage: holds one plan and sends its results one per cycle while m_ready is high.
`include "assert_macros.svh"

module h264rtp_emit (
    input  logic               aclk,
    input  logic               aresetn,
    input  h264rtp_pkg::plan_t plan,
    output logic               in_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_byte_valid,
    output logic               m_au_end,
    output logic               m_last_in_run
);
    import h264rtp_pkg::*;

    logic       busy_reg;
    logic [2:0] pos_reg;
    logic [2:0] count_reg;
    logic       sc_reg;
    logic       byte_en_reg;
    logic [7:0] data_reg;
    logic       au_reg;
    logic       last;
    logic [2:0] plan_count;

    // Results in a plan: start code, then the byte, or a lone flush marker.
    always_comb begin
        plan_count = (plan.start_code ? START_CODE_LEN : 3'd0) + {2'd0, plan.byte_en};
        if (plan_count == 3'd0) begin
            plan_count = 3'd1;
        end
    end

    assign last     = (pos_reg == count_reg - 3'd1);
    assign in_ready = !busy_reg || (m_ready && last);

    // Result selection for the current position.
    always_comb begin
        if (sc_reg && pos_reg < START_CODE_LEN) begin
            m_byte_valid = 1'b1;
            m_out_byte   = (pos_reg == START_CODE_LEN - 3'd1) ? 8'd1 : 8'd0;
        end else if (byte_en_reg) begin
            m_byte_valid = 1'b1;
            m_out_byte   = data_reg;
        end else begin
            m_byte_valid = 1'b0;
            m_out_byte   = 8'd0;
        end
    end

    assign m_valid       = busy_reg;
    assign m_last_in_run = last;
    assign m_au_end      = au_reg && last;

    // Plan register and position counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            pos_reg   <= 3'd0;
            count_reg <= 3'd0;
        end else if (plan.load) begin
            busy_reg  <= 1'b1;
            pos_reg   <= 3'd0;
            count_reg <= plan_count;
        end else if (busy_reg && m_ready) begin
            if (last) begin
                busy_reg <= 1'b0;
            end else begin
                pos_reg <= pos_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (plan.load) begin
            sc_reg      <= plan.start_code;
            byte_en_reg <= plan.byte_en;
            data_reg    <= plan.data;
            au_reg      <= plan.au_end;
        end
    end

    `ASSERT_IMPLIES(a_load_when_free, plan.load, in_ready, "plan loaded over a pending result")
    `ASSERT_IMPLIES(a_pos_in_range, busy_reg, pos_reg < count_reg, "result position out of range")
    `ASSERT_IMPLIES(a_flush_only, m_valid && !m_byte_valid, m_au_end,
        "empty result without access unit end")
    `ASSERT_IMPLIES(a_count_bound, busy_reg, count_reg <= START_CODE_LEN + 3'd1,
        "too many results in one plan")

endmodule

@@ hdl/h264_rtp_depacketizer.sv @@
// Top level of the H.264 RTP depacketizer: parser and output stage.
// The first result of an input transfer is presented the cycle after it.
// The output stage sends results as m_ready takes them; a plain payload byte is one
// result, while a start code holds the input until its bytes and any payload byte are sent.
// The output stage accepts the next byte in the cycle its last result is taken.
// Reset: synchronous active-low aresetn clears all packet state; no clearing pass.
module h264_rtp_depacketizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_of_packet,
    input  logic [15:0] s_packet_length,
    input  logic        s_rtp_marker,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_byte_valid,
    output logic        m_au_end,
    output logic        m_last_in_run
);
    import h264rtp_pkg::*;

    plan_t plan;

    // Byte parser with the packet state.
    h264rtp_parse u_parse (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .in_ready          (s_ready),
        .s_data_byte       (s_data_byte),
        .s_first_of_packet (s_first_of_packet),
        .s_packet_length   (s_packet_length),
        .s_rtp_marker      (s_rtp_marker),
        .plan              (plan)
    );

    // Result register and sequencer.
    h264rtp_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .plan          (plan),
        .in_ready      (s_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_byte_valid  (m_byte_valid),
        .m_au_end      (m_au_end),
        .m_last_in_run (m_last_in_run)
    );

endmodule
